/* design/assert_macros.svh */
// assertion helpers used by the lock table controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AOLT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define AOLT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* design/aolt_pkg.sv */
package aolt_pkg;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam int COUNT_BITS = 7;
  localparam int COUNT_MAX  = 127;

  // control part of the token that walks the cell chain
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       hit;
    logic       hit_taken;
    logic       held;
    logic       free_found;
  } tok_ctl_t;

  // commands the controller sends to every cell at once
  typedef struct packed {
    logic commit;
    logic undo;
    logic clr_taken;
    logic clr_pend;
  } bcast_t;

endpackage

/* design/aolt_cell.sv */
module aolt_cell #(
  parameter int KEY_BITS = 32,
  parameter int TXN_BITS = 16,
  parameter int CNT_W    = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [KEY_BITS-1:0]  key_i,
  input  logic [TXN_BITS-1:0]  txn_i,
  input  aolt_pkg::bcast_t     bc_i,
  input  aolt_pkg::tok_ctl_t   tok_i,
  input  logic [CNT_W-1:0]     nl_i,
  input  logic [CNT_W-1:0]     nlnt_i,
  output aolt_pkg::tok_ctl_t   tok_o,
  output logic [CNT_W-1:0]     nl_o,
  output logic [CNT_W-1:0]     nlnt_o
);
  import aolt_pkg::*;

  logic                locked_r, locked_nxt;
  logic                taken_r, taken_nxt;
  logic                pend_r, pend_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [TXN_BITS-1:0] holder_r;
  logic                vld_r;
  tok_ctl_t            tok_r, tok_nxt;
  logic [CNT_W-1:0]    nl_r, nl_nxt;
  logic [CNT_W-1:0]    nlnt_r, nlnt_nxt;

  logic visit, own, match, claim, drop;

  always_comb begin
    visit = tok_i.valid;
    own   = (holder_r == txn_i);
    match = locked_r && (key_r == key_i);
    // first free cell along the chain takes the key on trial
    claim = visit && (tok_i.op == OP_ACQUIRE) && !locked_r && !tok_i.free_found;
    drop  = visit && (tok_i.op == OP_RELEASE) && locked_r && own;

    locked_nxt = locked_r;
    taken_nxt  = taken_r;
    pend_nxt   = pend_r;
    if (drop) begin
      locked_nxt = 1'b0;
      taken_nxt  = 1'b0;
    end
    if (bc_i.commit && pend_r) begin
      locked_nxt = 1'b1;
      taken_nxt  = 1'b1;
    end
    if (bc_i.undo) begin
      if (taken_r) begin
        locked_nxt = 1'b0;
      end
      taken_nxt = 1'b0;
    end
    if (bc_i.clr_taken) begin
      taken_nxt = 1'b0;
    end
    if (claim) begin
      pend_nxt = 1'b1;
    end
    if (bc_i.clr_pend) begin
      pend_nxt = 1'b0;
    end

    tok_nxt            = tok_i;
    tok_nxt.hit        = tok_i.hit | match;
    tok_nxt.hit_taken  = tok_i.hit_taken | (match && taken_r);
    tok_nxt.held       = tok_i.held | (match && own);
    tok_nxt.free_found = tok_i.free_found | !locked_r;

    // running counts: locked after this cell acts, and locked outside the open request
    nl_nxt   = nl_i + CNT_W'(locked_r && !drop);
    nlnt_nxt = nlnt_i + CNT_W'(locked_r && !taken_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
      taken_r  <= 1'b0;
      pend_r   <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      locked_r <= locked_nxt;
      taken_r  <= taken_nxt;
      pend_r   <= pend_nxt;
      vld_r    <= visit;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      key_r    <= key_i;
      holder_r <= txn_i;
    end
    tok_r  <= tok_nxt;
    nl_r   <= nl_nxt;
    nlnt_r <= nlnt_nxt;
  end

  always_comb begin
    tok_o       = tok_r;
    tok_o.valid = vld_r;
    nl_o        = nl_r;
    nlnt_o      = nlnt_r;
  end

endmodule

/* design/aolt_ctrl.sv */
`include "assert_macros.svh"

module aolt_ctrl #(
  parameter int KEY_BITS = 32,
  parameter int TXN_BITS = 16,
  parameter int CNT_W    = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [TXN_BITS-1:0]           in_txn,
  input  logic [KEY_BITS-1:0]           in_key_id,
  input  logic                          in_last_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_done_op,
  output logic                          out_granted,
  output logic                          out_table_full,
  output logic                          out_key_locked,
  output logic                          out_key_held_by_txn,
  output logic [aolt_pkg::COUNT_BITS-1:0] out_locked_count,
  output logic [KEY_BITS-1:0]           key_o,
  output logic [TXN_BITS-1:0]           txn_o,
  output aolt_pkg::tok_ctl_t            tok_head_o,
  input  aolt_pkg::tok_ctl_t            tok_tail_i,
  input  logic [CNT_W-1:0]              nl_tail_i,
  input  logic [CNT_W-1:0]              nlnt_tail_i,
  output aolt_pkg::bcast_t              bc_o
);
  import aolt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  localparam int OW = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r;
  logic                last_r;
  logic                skip_r;
  logic                launch_r;
  logic [KEY_BITS-1:0] key_r;
  logic [TXN_BITS-1:0] txn_r;
  logic                failed_r, full_r;
  logic [CNT_W-1:0]    total_r;
  logic                hit_r, hit_taken_r, held_r, free_r;
  logic [CNT_W-1:0]    nl_r, nlnt_r;
  logic                out_valid_r;
  logic [1:0]          done_op_r;
  logic                granted_r, table_full_r, key_locked_r, held_out_r;
  logic [COUNT_BITS-1:0] count_r;

  logic                  in_accept, op_ok, need_out, fin_go;
  logic                  do_commit, do_undo, fail_set, full_set, fail_n, full_n;
  logic [CNT_W-1:0]      total_new;
  logic [OW-1:0]         tot_ext;
  logic [COUNT_BITS-1:0] count_sat;

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    in_accept = in_valid && in_ready;
    op_ok     = (in_op == OP_ACQUIRE) || (in_op == OP_RELEASE) || (in_op == OP_QUERY);
    need_out  = (op_r != OP_ACQUIRE) || last_r;
    fin_go    = (state_r == S_FIN) && (!need_out || !out_valid_r || out_ready);

    do_commit = 1'b0;
    do_undo   = 1'b0;
    fail_set  = 1'b0;
    full_set  = 1'b0;
    total_new = total_r;
    case (op_r) inside
      OP_ACQUIRE: begin
        if (!skip_r) begin
          if (hit_r) begin
            // a key locked by this same request is simply a repeat
            if (!hit_taken_r) begin
              do_undo   = 1'b1;
              fail_set  = 1'b1;
              total_new = nlnt_r;
            end else begin
              total_new = nl_r;
            end
          end else if (free_r) begin
            do_commit = 1'b1;
            total_new = nl_r + CNT_W'(1);
          end else begin
            do_undo   = 1'b1;
            fail_set  = 1'b1;
            full_set  = 1'b1;
            total_new = nlnt_r;
          end
        end
      end
      OP_RELEASE, OP_QUERY: begin
        total_new = nl_r;
      end
      default: ;
    endcase
    fail_n = failed_r | fail_set;
    full_n = full_r | full_set;

    tot_ext   = OW'(total_new);
    count_sat = (tot_ext > OW'(COUNT_MAX)) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(tot_ext);

    bc_o.commit    = fin_go && do_commit;
    bc_o.undo      = fin_go && do_undo;
    bc_o.clr_taken = fin_go && (op_r == OP_ACQUIRE) && last_r;
    bc_o.clr_pend  = fin_go;

    tok_head_o            = '0;
    tok_head_o.valid      = launch_r;
    tok_head_o.op         = op_r;
    key_o                 = key_r;
    txn_o                 = txn_r;

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && op_ok) begin
          // a request already refused skips the chain walk
          state_nxt = ((in_op == OP_ACQUIRE) && failed_r) ? S_FIN : S_RUN;
        end
      end
      S_RUN: begin
        if (tok_tail_i.valid) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      failed_r    <= 1'b0;
      full_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_accept && op_ok && !((in_op == OP_ACQUIRE) && failed_r);
      if (fin_go) begin
        total_r <= total_new;
        if (op_r == OP_ACQUIRE) begin
          if (last_r) begin
            failed_r <= 1'b0;
            full_r   <= 1'b0;
          end else begin
            failed_r <= fail_n;
            full_r   <= full_n;
          end
        end
      end
      if (fin_go && need_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_op;
      last_r <= in_last_key;
      key_r  <= in_key_id;
      txn_r  <= in_txn;
      skip_r <= (in_op == OP_ACQUIRE) && failed_r;
    end
    if ((state_r == S_RUN) && tok_tail_i.valid) begin
      hit_r       <= tok_tail_i.hit;
      hit_taken_r <= tok_tail_i.hit_taken;
      held_r      <= tok_tail_i.held;
      free_r      <= tok_tail_i.free_found;
      nl_r        <= nl_tail_i;
      nlnt_r      <= nlnt_tail_i;
    end
    if (fin_go && need_out) begin
      done_op_r    <= op_r;
      granted_r    <= (op_r == OP_ACQUIRE) && !fail_n;
      table_full_r <= (op_r == OP_ACQUIRE) && full_n;
      key_locked_r <= (op_r == OP_QUERY) && hit_r;
      held_out_r   <= (op_r == OP_QUERY) && held_r;
      count_r      <= count_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_done_op         = done_op_r;
  assign out_granted         = granted_r;
  assign out_table_full      = table_full_r;
  assign out_key_locked      = key_locked_r;
  assign out_key_held_by_txn = held_out_r;
  assign out_locked_count    = count_r;

  `AOLT_ASSERT(a_tail_in_run, clk, rst_n, tok_tail_i.valid |-> (state_r == S_RUN),
               "token left chain outside a walk")
  `AOLT_ASSERT(a_launch_run, clk, rst_n, launch_r |-> (state_r == S_RUN),
               "token launched without a walk")
  `AOLT_ASSERT(a_flags_clear, clk, rst_n,
               (fin_go && (op_r == OP_ACQUIRE) && last_r) |=> (!failed_r && !full_r),
               "request flags survived the last key")
  `AOLT_ASSERT(a_full_fail, clk, rst_n, full_r |-> failed_r,
               "table full flag without refusal")
  `AOLT_NEVER(a_bc_excl, clk, rst_n, bc_o.commit && bc_o.undo,
              "commit and undo together")

endmodule

/* design/all_or_nothing_lock_table.sv */
// walk: an item walks the chain of TABLE_SLOTS cells, one cell per cycle; its result
//   is registered after the token leaves the last cell and the controller finishes it
// flow: a new item is accepted only once the last one is finished; a key item of an
//   already refused request skips the walk; a waiting result holds off the next item
// reset: synchronous active-low rst_n clears lock, taken and trial bits, request flags and
//   the locked count; slot key and holder registers are not reset
module all_or_nothing_lock_table #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BITS    = 32,
  parameter int TXN_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [TXN_BITS-1:0]             in_txn,
  input  logic [KEY_BITS-1:0]             in_key_id,
  input  logic                            in_last_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_done_op,
  output logic                            out_granted,
  output logic                            out_table_full,
  output logic                            out_key_locked,
  output logic                            out_key_held_by_txn,
  output logic [aolt_pkg::COUNT_BITS-1:0] out_locked_count
);
  import aolt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  tok_ctl_t            tok_w  [0:TABLE_SLOTS];
  logic [CNT_W-1:0]    nl_w   [0:TABLE_SLOTS];
  logic [CNT_W-1:0]    nlnt_w [0:TABLE_SLOTS];
  logic [KEY_BITS-1:0] key_w;
  logic [TXN_BITS-1:0] txn_w;
  bcast_t              bc_w;

  assign nl_w[0]   = '0;
  assign nlnt_w[0] = '0;

  aolt_ctrl #(
    .KEY_BITS (KEY_BITS),
    .TXN_BITS (TXN_BITS),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_txn              (in_txn),
    .in_key_id           (in_key_id),
    .in_last_key         (in_last_key),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_done_op         (out_done_op),
    .out_granted         (out_granted),
    .out_table_full      (out_table_full),
    .out_key_locked      (out_key_locked),
    .out_key_held_by_txn (out_key_held_by_txn),
    .out_locked_count    (out_locked_count),
    .key_o               (key_w),
    .txn_o               (txn_w),
    .tok_head_o          (tok_w[0]),
    .tok_tail_i          (tok_w[TABLE_SLOTS]),
    .nl_tail_i           (nl_w[TABLE_SLOTS]),
    .nlnt_tail_i         (nlnt_w[TABLE_SLOTS]),
    .bc_o                (bc_w)
  );

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    aolt_cell #(
      .KEY_BITS (KEY_BITS),
      .TXN_BITS (TXN_BITS),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .key_i  (key_w),
      .txn_i  (txn_w),
      .bc_i   (bc_w),
      .tok_i  (tok_w[g]),
      .nl_i   (nl_w[g]),
      .nlnt_i (nlnt_w[g]),
      .tok_o  (tok_w[g+1]),
      .nl_o   (nl_w[g+1]),
      .nlnt_o (nlnt_w[g+1])
    );
  end

endmodule

/* verif/tb_all_or_nothing_lock_table.sv */
`timescale 1ns / 1ps

module tb_all_or_nothing_lock_table;
  import aolt_pkg::*;

  localparam int TABLE_SLOTS      = 64;
  localparam int KEY_BITS         = 32;
  localparam int TXN_BITS         = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET      = 1120;
  localparam int LONG_HOLD_CYCLES = 600;

  typedef struct packed {
    logic [1:0]          op;
    logic [TXN_BITS-1:0] txn;
    logic [KEY_BITS-1:0] key_id;
    logic                last_key;
  } lock_req_t;

  typedef struct packed {
    logic [1:0]            done_op;
    logic                  granted;
    logic                  table_full;
    logic                  key_locked;
    logic                  key_held;
    logic [COUNT_BITS-1:0] count;
  } lock_resp_t;

  typedef struct {
    lock_req_t  req;
    bit         typed;
    lock_resp_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_op;
  logic [TXN_BITS-1:0]   in_txn;
  logic [KEY_BITS-1:0]   in_key_id;
  logic                  in_last_key;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_done_op;
  logic                  out_granted;
  logic                  out_table_full;
  logic                  out_key_locked;
  logic                  out_key_held_by_txn;
  logic [COUNT_BITS-1:0] out_locked_count;

  all_or_nothing_lock_table #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_BITS   (KEY_BITS),
    .TXN_BITS   (TXN_BITS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_txn             (in_txn),
    .in_key_id          (in_key_id),
    .in_last_key        (in_last_key),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_done_op        (out_done_op),
    .out_granted        (out_granted),
    .out_table_full     (out_table_full),
    .out_key_locked     (out_key_locked),
    .out_key_held_by_txn(out_key_held_by_txn),
    .out_locked_count   (out_locked_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // shadow copy of the lock table
  logic [KEY_BITS-1:0] lk_key    [TABLE_SLOTS];
  logic [TXN_BITS-1:0] lk_holder [TABLE_SLOTS];
  bit                  lk_locked [TABLE_SLOTS];
  bit                  lk_taken  [TABLE_SLOTS];
  bit                  req_failed;
  bit                  req_full;
  int                  lock_total;

  lock_resp_t pending_answers[$];
  plan_row_t  plan[$];

  bit idle_on;
  bit hold_off_req;
  int items_sent;
  int fail_count;
  int grants;
  int refusals;
  int full_refusals;
  int queries;
  int peak_locks;

  function automatic int slot_of_key(input logic [KEY_BITS-1:0] key);
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (lk_locked[i] && lk_key[i] == key) return i;
    return -1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] locks_reported();
    return (lock_total > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(lock_total);
  endfunction

  // returns 1 when the item produces an answer
  function automatic bit resolve_lock_op(input lock_req_t r, output lock_resp_t res);
    int hit;
    int free_idx;
    res = '0;
    res.done_op = r.op;
    hit = slot_of_key(r.key_id);
    case (r.op)
      OP_ACQUIRE: begin
        if (!req_failed) begin
          free_idx = -1;
          for (int i = TABLE_SLOTS - 1; i >= 0; i--)
            if (!lk_locked[i]) free_idx = i;
          if (hit >= 0 && lk_taken[hit]) begin
            // key already taken by this request, nothing to do
          end else if (hit < 0 && free_idx >= 0) begin
            lk_key[free_idx]    = r.key_id;
            lk_holder[free_idx] = r.txn;
            lk_locked[free_idx] = 1'b1;
            lk_taken[free_idx]  = 1'b1;
            lock_total++;
            if (lock_total > peak_locks) peak_locks = lock_total;
          end else begin
            // roll back everything this request took
            for (int i = 0; i < TABLE_SLOTS; i++) begin
              if (lk_taken[i] && lk_locked[i]) begin
                lk_locked[i] = 1'b0;
                if (lock_total > 0) lock_total--;
              end
              lk_taken[i] = 1'b0;
            end
            req_failed = 1'b1;
            req_full   = (hit < 0);
          end
        end
        if (!r.last_key) return 1'b0;
        res.granted    = !req_failed;
        res.table_full = req_full;
        res.count      = locks_reported();
        for (int i = 0; i < TABLE_SLOTS; i++) lk_taken[i] = 1'b0;
        req_failed = 1'b0;
        req_full   = 1'b0;
      end
      OP_RELEASE: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (lk_locked[i] && lk_holder[i] == r.txn) begin
            lk_locked[i] = 1'b0;
            lk_taken[i]  = 1'b0;
            if (lock_total > 0) lock_total--;
          end
        end
        res.count = locks_reported();
      end
      OP_QUERY: begin
        res.key_locked = (hit >= 0);
        res.key_held   = (hit >= 0) && (lk_holder[hit] == r.txn);
        res.count      = locks_reported();
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic plan_row_t plan_row(input logic [1:0] op, input logic [TXN_BITS-1:0] txn,
      input logic [KEY_BITS-1:0] key, input logic last_key, input int typed,
      input int granted, input int full, input int locked, input int held,
      input int count);
    plan_row_t p;
    p.req.op          = op;
    p.req.txn         = txn;
    p.req.key_id      = key;
    p.req.last_key    = last_key;
    p.typed           = (typed != 0);
    p.want.done_op    = op;
    p.want.granted    = (granted != 0);
    p.want.table_full = (full != 0);
    p.want.key_locked = (locked != 0);
    p.want.key_held   = (held != 0);
    p.want.count      = COUNT_BITS'(count);
    return p;
  endfunction

  task automatic send_item(input lock_req_t r, input bit typed, input lock_resp_t typed_res);
    lock_resp_t res;
    lock_resp_t ans;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= r.op;
    in_txn      <= r.txn;
    in_key_id   <= r.key_id;
    in_last_key <= r.last_key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (resolve_lock_op(r, res)) begin
      ans = typed ? typed_res : res;
      pending_answers = {pending_answers, ans};
      if (res.done_op == OP_ACQUIRE) begin
        if (res.granted) grants++;
        else refusals++;
        if (res.table_full) full_refusals++;
      end else if (res.done_op == OP_QUERY) begin
        queries++;
      end
    end
  endtask

  task automatic check_answer();
    lock_resp_t got;
    lock_resp_t want;
    got.done_op    = out_done_op;
    got.granted    = out_granted;
    got.table_full = out_table_full;
    got.key_locked = out_key_locked;
    got.key_held   = out_key_held_by_txn;
    got.count      = out_locked_count;
    if (pending_answers.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected answer op %0d count %0d", $realtime, got.done_op, got.count);
    end else begin
      want = pending_answers.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: mismatch exp op %0d gr %b full %b lk %b held %b cnt %0d",
                    " / got op %0d gr %b full %b lk %b held %b cnt %0d"},
                   $realtime, want.done_op, want.granted, want.table_full, want.key_locked,
                   want.key_held, want.count, got.done_op, got.granted, got.table_full,
                   got.key_locked, got.key_held, got.count);
      end
    end
  endtask

  // answer side: random stalls plus one long hold-off on request
  initial begin : answer_side
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_answer();
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d answers pending", pending_answers.size());
    $display("simulation failed");
    $finish;
  end

  initial begin : request_side
    lock_req_t           r;
    lock_req_t           stray;
    logic [TXN_BITS-1:0] txn_pool [8];
    logic [KEY_BITS-1:0] hot_keys [16];
    logic [TXN_BITS-1:0] req_txn;
    int                  nkeys;
    int                  pick;
    int                  sel;
    bit                  fill_phase;
    bit                  hold_done;
    bit                  drain_done;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_ACQUIRE;
    in_txn       = '0;
    in_key_id    = '0;
    in_last_key  = 1'b0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    req_failed   = 1'b0;
    req_full     = 1'b0;
    lock_total   = 0;

    txn_pool[0] = '0;
    txn_pool[1] = '1;
    for (int i = 2; i < 8; i++) txn_pool[i] = TXN_BITS'($urandom);
    hot_keys[0] = '0;
    hot_keys[1] = '1;
    for (int i = 2; i < 16; i++) hot_keys[i] = $urandom;

    // op, txn, key, last, typed, granted, full, locked, held, count
    plan = {plan, plan_row(OP_QUERY,   16'h0000, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_RELEASE, 16'hFFFF, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_UNUSED,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, 0, 0, 0, 0, 0, 0)};
    // two-key request with a repeated key
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0001, 32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0001, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0001, 32'hFFFF_FFFF, 1'b1, 1, 1, 0, 0, 0, 2)};
    plan = {plan, plan_row(OP_QUERY,   16'h0001, 32'hFFFF_FFFF, 1'b0, 1, 0, 0, 1, 1, 2)};
    plan = {plan, plan_row(OP_QUERY,   16'hFFFF, 32'h0000_0000, 1'b0, 1, 0, 0, 1, 0, 2)};
    // holder asks again for its own key
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0001, 32'h0000_0000, 1'b1, 1, 0, 0, 0, 0, 2)};
    // conflict mid request, rest ignored until the marked item
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0002, 32'h0000_0005, 1'b0, 0, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0002, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0002, 32'h0000_0006, 1'b1, 1, 0, 0, 0, 0, 2)};
    plan = {plan, plan_row(OP_QUERY,   16'h0002, 32'h0000_0005, 1'b0, 1, 0, 0, 0, 0, 2)};
    // mixed txn, query and release inside an open request
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0003, 32'h0000_0007, 1'b0, 0, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0004, 32'h0000_0008, 1'b0, 0, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_QUERY,   16'h0003, 32'h0000_0007, 1'b0, 1, 0, 0, 1, 1, 4)};
    plan = {plan, plan_row(OP_RELEASE, 16'h0004, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 0, 3)};
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0003, 32'h0000_0009, 1'b1, 1, 1, 0, 0, 0, 4)};
    plan = {plan, plan_row(OP_QUERY,   16'h0004, 32'h0000_0008, 1'b0, 1, 0, 0, 0, 0, 4)};
    plan = {plan, plan_row(OP_RELEASE, 16'h0001, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 0, 2)};
    plan = {plan, plan_row(OP_RELEASE, 16'h0003, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_RELEASE, 16'h0003, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 0, 0)};
    plan = {plan, plan_row(OP_ACQUIRE, 16'h0000, 32'h8000_0001, 1'b1, 1, 1, 0, 0, 0, 1)};
    plan = {plan, plan_row(OP_RELEASE, 16'h0000, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 0, 0)};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i].req, plan[i].typed, plan[i].want);

    while (items_sent < ITEM_TARGET) begin
      // fill phase drives the table to full; calm stretch and tail have no idling
      fill_phase = (items_sent >= 450 && items_sent < 650);
      idle_on    = !(items_sent >= 300 && items_sent < 380) && items_sent < 950;
      if (!hold_done && items_sent >= 200) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!drain_done && items_sent >= 700) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_answers.size() != 0);
        drain_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < (fill_phase ? 80 : 55)) begin
        nkeys   = fill_phase ? $urandom_range(3, 10) : $urandom_range(1, 4);
        req_txn = txn_pool[$urandom_range(0, 7)];
        for (int k = 0; k < nkeys; k++) begin
          sel = $urandom_range(0, 9);
          r.op       = OP_ACQUIRE;
          r.last_key = (k == nkeys - 1);
          r.txn      = ($urandom_range(0, 24) == 0) ? txn_pool[$urandom_range(0, 7)] : req_txn;
          if (k > 0 && sel == 0) begin
            // repeat the previous key
          end else if (sel < (fill_phase ? 2 : 6)) begin
            r.key_id = hot_keys[$urandom_range(0, 15)];
          end else begin
            r.key_id = $urandom;
          end
          if ($urandom_range(0, 24) == 0) begin
            stray.op       = 2'($urandom_range(1, 3));
            stray.txn      = txn_pool[$urandom_range(0, 7)];
            stray.key_id   = hot_keys[$urandom_range(0, 15)];
            stray.last_key = 1'($urandom);
            send_item(stray, 1'b0, '0);
          end
          send_item(r, 1'b0, '0);
        end
      end else if (pick < (fill_phase ? 83 : 75)) begin
        r.op       = OP_RELEASE;
        r.txn      = txn_pool[$urandom_range(0, 7)];
        r.key_id   = $urandom;
        r.last_key = 1'($urandom);
        send_item(r, 1'b0, '0);
      end else if (pick < 95) begin
        r.op       = OP_QUERY;
        r.txn      = txn_pool[$urandom_range(0, 7)];
        r.key_id   = ($urandom_range(0, 9) < 7) ? hot_keys[$urandom_range(0, 15)] : $urandom;
        r.last_key = 1'($urandom);
        send_item(r, 1'b0, '0);
      end else begin
        // noise: unused op, unmarked stray key, release of an unknown txn
        sel        = $urandom_range(0, 2);
        r.op       = (sel == 0) ? OP_UNUSED : (sel == 1) ? OP_ACQUIRE : OP_RELEASE;
        r.txn      = TXN_BITS'($urandom);
        r.key_id   = $urandom;
        r.last_key = (sel == 1) ? 1'b0 : 1'($urandom);
        send_item(r, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
    repeat (TABLE_SLOTS + 4) @(posedge clk);

    $display("covered %0d items: %0d grants, %0d refusals (%0d with table full), %0d queries",
             items_sent, grants, refusals, full_refusals, queries);
    $display("lock count peaked at %0d of %0d slots, %0d mismatches",
             peak_locks, TABLE_SLOTS, fail_count);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
